// ===== hdl/spp_pkg.sv =====
package spp_pkg;

  localparam int TABLE_LEN = 24;
  localparam logic signed [19:0] FULL_TURN = 20'sd368640;
  localparam logic signed [19:0] HALF_TURN = 20'sd184320;
  localparam logic [15:0] INV_GAIN = 16'd39797;
  localparam logic signed [19:0] COORD_MAX = 20'sd524287;
  localparam logic signed [19:0] COORD_MIN = -20'sd524288;

  localparam logic [2:0] REG_CORNER = 3'd0;
  localparam logic [2:0] REG_COL_STEP = 3'd1;
  localparam logic [2:0] REG_ROW_STEP = 3'd2;
  localparam logic [2:0] REG_CENTER = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;
  localparam logic [2:0] REG_INV_DEG = 3'd5;
  localparam logic [2:0] REG_COLS = 3'd6;
  localparam logic [2:0] REG_ROWS = 3'd7;

  typedef struct packed {
    logic [11:0] frustum_row;
    logic [11:0] frustum_col;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } in_req_t;

  typedef struct packed {
    logic [11:0] pano_col;
    logic [10:0] pano_row;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
  } out_req_t;

  typedef struct packed {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] pz;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } point_t;

  typedef struct packed {
    logic [59:0] corner;
    logic [59:0] col_step;
    logic [59:0] row_step;
    logic [59:0] center;
    logic [39:0] radius2;
    logic [19:0] inv_deg;
    logic [12:0] cols;
    logic [11:0] rows;
  } cfg_t;

  function automatic logic signed [19:0] atan_deg(input int i);
    logic signed [19:0] t;
    case (i)
      0: t = 20'sd46080;  1: t = 20'sd27203;  2: t = 20'sd14373;
      3: t = 20'sd7296;   4: t = 20'sd3662;   5: t = 20'sd1833;
      6: t = 20'sd917;    7: t = 20'sd458;    8: t = 20'sd229;
      9: t = 20'sd115;    10: t = 20'sd57;    11: t = 20'sd29;
      12: t = 20'sd14;    13: t = 20'sd7;     14: t = 20'sd4;
      15: t = 20'sd2;     16: t = 20'sd1;
      default: t = 20'sd0;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/spp_front.sv =====
module spp_front #(
  parameter int INDEX_BITS = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  spp_pkg::in_req_t in_data,
  input  spp_pkg::cfg_t  cfg,
  output logic           pt_valid,
  output spp_pkg::point_t pt_data
);
  import spp_pkg::*;

  logic [11:0] imask;
  assign imask = 12'((13'd1 << INDEX_BITS) - 13'd1);

  // stage 1: products
  logic          s1_v_r;
  in_req_t       s1_d_r;
  logic signed [33:0] cp_r [3];
  logic signed [33:0] rp_r [3];
  // stage 2: point
  logic          s2_v_r;
  in_req_t       s2_d_r;
  logic signed [19:0] p_r [3];
  // stage 3: squares
  logic          s3_v_r;
  in_req_t       s3_d_r;
  logic signed [19:0] p3_r [3];
  logic [41:0]   sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_d_r <= in_data;
    s2_d_r <= s1_d_r;
    s3_d_r <= s2_d_r;
    for (int k = 0; k < 3; k++) begin
      cp_r[k] <= $signed({1'b0, in_data.frustum_col & imask}) *
                 $signed(cfg.col_step[20*k +: 20]);
      rp_r[k] <= $signed({1'b0, in_data.frustum_row & imask}) *
                 $signed(cfg.row_step[20*k +: 20]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [35:0] sum;
      logic signed [33:0] q;
      sum = 36'($signed(cfg.corner[20*k +: 20])) * 36'sd4 + 36'(cp_r[k]) + 36'(rp_r[k]);
      q = 34'(sum >>> 2);
      if (q > 34'(COORD_MAX)) p_r[k] <= COORD_MAX;
      else if (q < 34'(COORD_MIN)) p_r[k] <= COORD_MIN;
      else p_r[k] <= 20'(q);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [20:0] d;
      d = 21'($signed(cfg.center[20*k +: 20])) - 21'(p_r[k]);
      sq_r[k] <= 42'(42'(d) * 42'(d));
      p3_r[k] <= p_r[k];
    end
  end

  logic [43:0] dist2;
  assign dist2 = 44'(sq_r[0]) + 44'(sq_r[1]) + 44'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) pt_valid <= 1'b0;
    else pt_valid <= s3_v_r && (dist2 < 44'(cfg.radius2));
  end

  always_ff @(posedge clk) begin
    pt_data <= '{px: p3_r[0], py: p3_r[1], pz: p3_r[2],
                 blue: s3_d_r.blue, green: s3_d_r.green, red: s3_d_r.red};
  end
endmodule

// ===== hdl/spp_fifo.sv =====
module spp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  spp_pkg::point_t wr_data,
  output logic            rd_valid,
  output spp_pkg::point_t rd_data
);
  import spp_pkg::*;

  point_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  // back end never stalls, so one entry is popped whenever present
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (cnt_r != 3'd0);
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (cnt_r != 3'd0) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr_en) - 3'(cnt_r != 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
    rd_data <= mem_r[rp_r];
  end
endmodule

// ===== hdl/spp_back.sv =====
module spp_back #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pt_valid,
  input  spp_pkg::point_t pt_data,
  input  spp_pkg::cfg_t   cfg,
  output logic            out_valid,
  output spp_pkg::out_req_t out_data
);
  import spp_pkg::*;

  localparam int N = CORDIC_ITERATIONS;
  localparam int W = 36;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [20:0]  a;
  } cst_t;

  // pass 1: lon over (x,z); y and colour ride along
  logic        v1_r [N+1];
  cst_t        c1_r [N+1];
  logic signed [19:0] y1_r [N+1];
  logic [23:0] col1_r [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) v1_r[i] <= 1'b0;
    end else begin
      v1_r[0] <= pt_valid;
      for (int i = 0; i < N; i++) v1_r[i+1] <= v1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [W-1:0] x0, y0;
    x0 = W'(pt_data.px) <<< 8;
    y0 = W'(pt_data.pz) <<< 8;
    if (x0 < 0) begin
      c1_r[0] <= '{x: -x0, y: -y0,
                   a: (y0 >= 0) ? 21'(HALF_TURN) : -21'(HALF_TURN)};
    end else begin
      c1_r[0] <= '{x: x0, y: y0, a: '0};
    end
    y1_r[0] <= pt_data.py;
    col1_r[0] <= {pt_data.blue, pt_data.green, pt_data.red};
    for (int i = 0; i < N; i++) begin
      if (c1_r[i].y >= 0)
        c1_r[i+1] <= '{x: c1_r[i].x + (c1_r[i].y >>> i), y: c1_r[i].y - (c1_r[i].x >>> i),
                       a: c1_r[i].a + 21'(atan_deg(i))};
      else
        c1_r[i+1] <= '{x: c1_r[i].x - (c1_r[i].y >>> i), y: c1_r[i].y + (c1_r[i].x >>> i),
                       a: c1_r[i].a - 21'(atan_deg(i))};
      y1_r[i+1] <= y1_r[i];
      col1_r[i+1] <= col1_r[i];
    end
  end

  // gain compensation and longitude wrap
  logic        vg_r;
  logic signed [W-1:0] rc_r;
  logic signed [20:0]  lon_r;
  logic signed [19:0]  yg_r;
  logic [23:0] colg_r;

  always_ff @(posedge clk) begin
    logic signed [W+17:0] m;
    logic signed [20:0] l;
    if (!rst_n) vg_r <= 1'b0;
    else vg_r <= v1_r[N];
    m = (W+18)'(c1_r[N].x) * $signed({2'b0, INV_GAIN});
    rc_r <= W'(m >>> 16);
    l = -c1_r[N].a;
    lon_r <= (l < 0) ? l + 21'(FULL_TURN) : l;
    yg_r <= y1_r[N];
    colg_r <= col1_r[N];
  end

  // pass 2: lat over (y, rcomp)
  logic        v2_r [N+1];
  cst_t        c2_r [N+1];
  logic signed [20:0] lon2_r [N+1];
  logic [23:0] col2_r [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) v2_r[i] <= 1'b0;
    end else begin
      v2_r[0] <= vg_r;
      for (int i = 0; i < N; i++) v2_r[i+1] <= v2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [W-1:0] x0;
    x0 = W'(yg_r) <<< 8;
    if (x0 < 0) begin
      c2_r[0] <= '{x: -x0, y: -rc_r,
                   a: (rc_r >= 0) ? 21'(HALF_TURN) : -21'(HALF_TURN)};
    end else begin
      c2_r[0] <= '{x: x0, y: rc_r, a: '0};
    end
    lon2_r[0] <= lon_r;
    col2_r[0] <= colg_r;
    for (int i = 0; i < N; i++) begin
      if (c2_r[i].y >= 0)
        c2_r[i+1] <= '{x: c2_r[i].x + (c2_r[i].y >>> i), y: c2_r[i].y - (c2_r[i].x >>> i),
                       a: c2_r[i].a + 21'(atan_deg(i))};
      else
        c2_r[i+1] <= '{x: c2_r[i].x - (c2_r[i].y >>> i), y: c2_r[i].y + (c2_r[i].x >>> i),
                       a: c2_r[i].a - 21'(atan_deg(i))};
      lon2_r[i+1] <= lon2_r[i];
      col2_r[i+1] <= col2_r[i];
    end
  end

  // scale to pixels
  logic        vs_r;
  logic signed [42:0] qu_r, qv_r;
  logic [23:0] cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= 1'b0;
    else vs_r <= v2_r[N];
    qu_r <= 43'(lon2_r[N]) * $signed({1'b0, cfg.inv_deg});
    qv_r <= 43'(c2_r[N].a) * $signed({1'b0, cfg.inv_deg});
    cols_r <= col2_r[N];
  end

  // clamp
  always_ff @(posedge clk) begin
    logic signed [21:0] u, v, cl, rw;
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= vs_r;
    u = (qu_r >= 0) ? 22'(qu_r >>> 22) : -22'((-qu_r) >>> 22);
    v = (qv_r >= 0) ? 22'(qv_r >>> 22) : -22'((-qv_r) >>> 22);
    cl = (cfg.cols > 13'd4096) ? 22'sd4096 : 22'($signed({1'b0, cfg.cols}));
    rw = (cfg.rows > 12'd2048) ? 22'sd2048 : 22'($signed({1'b0, cfg.rows}));
    v = rw - 22'sd1 - v;
    if (u >= cl) u = cl - 22'sd1;
    if (u < 0) u = '0;
    if (v >= rw) v = rw - 22'sd1;
    if (v < 0) v = '0;
    out_data <= '{pano_col: u[11:0], pano_row: v[10:0],
                  out_blue: cols_r[23:16], out_green: cols_r[15:8], out_red: cols_r[7:0]};
  end
endmodule

// ===== hdl/sphere_pixel_projection_core.sv =====
// channel | ports                               | timing
// in      | start, busy, in_data                | accepted when start && !busy
// out     | out_strobe, out_data               | one cycle per result
// cfg     | cfg_we, cfg_index, cfg_data        | written when cfg_we
// One pixel per cycle; each result passes the front end, the FIFO and
// the two pipelined CORDIC passes of the back end. Synchronous active-low
// reset clears valids and loads register defaults. busy stays low; no stalls.
module sphere_pixel_projection_core #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int INDEX_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spp_pkg::in_req_t   in_data,
  output logic               out_strobe,
  output spp_pkg::out_req_t  out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [59:0]        cfg_data
);
  import spp_pkg::*;

  cfg_t cfg_r;
  logic pt_v, q_v;
  point_t pt_d, q_d;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{corner: '0, col_step: '0, row_step: '0, center: '0, radius2: '0,
                 inv_deg: 20'd13653, cols: 13'd1200, rows: 12'd600};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CORNER:   cfg_r.corner <= cfg_data;
        REG_COL_STEP: cfg_r.col_step <= cfg_data;
        REG_ROW_STEP: cfg_r.row_step <= cfg_data;
        REG_CENTER:   cfg_r.center <= cfg_data;
        REG_RADIUS:   cfg_r.radius2 <= cfg_data[39:0];
        REG_INV_DEG:  cfg_r.inv_deg <= cfg_data[19:0];
        REG_COLS:     cfg_r.cols <= cfg_data[12:0];
        REG_ROWS:     cfg_r.rows <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  spp_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .in_data(in_data),
    .cfg(cfg_r), .pt_valid(pt_v), .pt_data(pt_d));

  spp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(pt_v), .wr_data(pt_d),
    .rd_valid(q_v), .rd_data(q_d));

  spp_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .pt_valid(q_v), .pt_data(q_d), .cfg(cfg_r),
    .out_valid(out_strobe), .out_data(out_data));
endmodule

// ===== hdl/spp_checker.sv =====
module spp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input spp_pkg::out_req_t out_data
);
  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy asserted");
  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe right after reset");
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_strobe)
    else $error("strobe too early");
  a_start_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(start))
    else $error("start unknown");
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown(out_data))
    else $error("result unknown");
endmodule

bind sphere_pixel_projection_core spp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_data(out_data));

// ===== test/tb_sphere_pixel_projection_core.sv =====
`timescale 1ns / 1ps

module tb_sphere_pixel_projection_core;
  import spp_pkg::*;

  class pixel_scoreboard;
    logic [59:0] corner, col_step, row_step, center;
    logic [39:0] radius2;
    logic [19:0] inv_deg;
    logic [12:0] cols;
    logic [11:0] rows;
    out_req_t    expected_px[$];
    int          fails;

    function new();
      corner = '0; col_step = '0; row_step = '0; center = '0; radius2 = '0;
      inv_deg = 20'd13653; cols = 13'd1200; rows = 12'd600; fails = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [59:0] val);
      case (idx)
        REG_CORNER:   corner = val;
        REG_COL_STEP: col_step = val;
        REG_ROW_STEP: row_step = val;
        REG_CENTER:   center = val;
        REG_RADIUS:   radius2 = val[39:0];
        REG_INV_DEG:  inv_deg = val[19:0];
        REG_COLS:     cols = val[12:0];
        REG_ROWS:     rows = val[11:0];
        default: ;
      endcase
    endfunction

    function longint comp(logic [59:0] v, int k);
      logic signed [19:0] f;
      f = v[20*k +: 20];
      return longint'(f);
    endfunction

    function longint arc_step(int i);
      case (i)
        0: return 46080;  1: return 27203;  2: return 14373;  3: return 7296;
        4: return 3662;   5: return 1833;   6: return 917;    7: return 458;
        8: return 229;    9: return 115;    10: return 57;    11: return 29;
        12: return 14;    13: return 7;     14: return 4;     15: return 2;
        16: return 1;
        default: return 0;
      endcase
    endfunction

    function longint rotate_angle(longint x, longint y, output longint mag);
      longint ang, dx, dy;
      ang = 0;
      if (x < 0) begin
        ang = (y >= 0) ? 184320 : -184320;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; ang += arc_step(i);
        end else begin
          x -= dx; y += dy; ang -= arc_step(i);
        end
      end
      mag = x;
      return ang;
    endfunction

    function longint to_px(longint ang);
      longint q;
      q = ang * longint'({1'b0, inv_deg});
      return (q >= 0) ? (q >>> 22) : -((-q) >>> 22);
    endfunction

    function longint clamp_to(longint v, longint size);
      if (v >= size) v = size - 1;
      if (v < 0) v = 0;
      return v;
    endfunction

    function void note_request(in_req_t r);
      longint p[3], s, d, rxz, dummy, lon, lat, rc, u, v, nc, nr;
      logic [63:0] dist2;
      out_req_t e;
      dist2 = 0;
      for (int k = 0; k < 3; k++) begin
        s = comp(corner, k) * 4 + longint'({1'b0, r.frustum_col}) * comp(col_step, k)
            + longint'({1'b0, r.frustum_row}) * comp(row_step, k);
        s = s >>> 2;
        if (s > 524287) s = 524287;
        if (s < -524288) s = -524288;
        p[k] = s;
        d = comp(center, k) - s;
        dist2 += d * d;
      end
      if (dist2 >= {24'd0, radius2}) return;
      lon = -rotate_angle(p[0] * 256, p[2] * 256, rxz);
      if (lon < 0) lon += 368640;
      rc = (rxz * 39797) >>> 16;
      lat = rotate_angle(p[1] * 256, rc, dummy);
      nc = cols > 4096 ? 4096 : cols;
      nr = rows > 2048 ? 2048 : rows;
      u = clamp_to(to_px(lon), nc);
      v = clamp_to(nr - 1 - to_px(lat), nr);
      e.pano_col = u[11:0];
      e.pano_row = v[10:0];
      e.out_blue = r.blue;
      e.out_green = r.green;
      e.out_red = r.red;
      expected_px = {expected_px, e};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fails++;
    endtask

    task check_result(out_req_t got);
      out_req_t e;
      if (expected_px.size() == 0) begin
        report($sformatf("unexpected pixel %h", got));
        return;
      end
      e = expected_px.pop_front();
      if (got.pano_col !== e.pano_col)
        report($sformatf("pano_col %0d want %0d", got.pano_col, e.pano_col));
      if (got.pano_row !== e.pano_row)
        report($sformatf("pano_row %0d want %0d", got.pano_row, e.pano_row));
      if (got.out_blue !== e.out_blue)
        report($sformatf("blue %0d want %0d", got.out_blue, e.out_blue));
      if (got.out_green !== e.out_green)
        report($sformatf("green %0d want %0d", got.out_green, e.out_green));
      if (got.out_red !== e.out_red)
        report($sformatf("red %0d want %0d", got.out_red, e.out_red));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_req_t     in_data = '0;
  logic        out_strobe;
  out_req_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [59:0] cfg_data = '0;
  bit          idle_on = 1'b1;

  pixel_scoreboard sb = new();

  always #1 clk = ~clk;

  sphere_pixel_projection_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_request(in_data);
    if (rst_n && out_strobe) sb.check_result(out_data);
  end

  task write_reg(logic [2:0] idx, logic [59:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task send_pixel(in_req_t r);
    if (idle_on && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task drain();
    start <= 1'b0;
    while (sb.expected_px.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function logic [59:0] rand_vec();
    return {28'($urandom), $urandom};
  endfunction

  function logic [59:0] small_vec(int span);
    logic [19:0] c[3];
    for (int k = 0; k < 3; k++) c[k] = 20'($urandom_range(0, 2 * span) - span);
    return {c[2], c[1], c[0]};
  endfunction

  function in_req_t rand_pixel();
    in_req_t r;
    r = in_req_t'({$urandom, 8'($urandom)});
    if ($urandom_range(0, 3) == 0) begin
      r.frustum_row = 12'($urandom_range(0, 15));
      r.frustum_col = 12'($urandom_range(0, 15));
    end
    return r;
  endfunction

  task set_phase(int ph);
    case (ph)
      0: begin
        write_reg(REG_CORNER, '0); write_reg(REG_COL_STEP, '0);
        write_reg(REG_ROW_STEP, '0); write_reg(REG_CENTER, small_vec(1000));
        write_reg(REG_RADIUS, {20'd0, 40'hFF_FFFF_FFFF}); write_reg(REG_INV_DEG, 60'd1);
        write_reg(REG_COLS, 60'd0); write_reg(REG_ROWS, 60'd0);
      end
      1: begin
        write_reg(REG_CORNER, {60{1'b1}}); write_reg(REG_COL_STEP, {60{1'b1}});
        write_reg(REG_ROW_STEP, {3{20'h7FFFF}}); write_reg(REG_CENTER, {3{20'h80000}});
        write_reg(REG_RADIUS, {20'd0, 40'hFF_FFFF_FFFF}); write_reg(REG_INV_DEG, 60'hFFFFF);
        write_reg(REG_COLS, 60'h1FFF); write_reg(REG_ROWS, 60'hFFF);
      end
      2: begin
        write_reg(REG_CORNER, small_vec(200000)); write_reg(REG_COL_STEP, small_vec(100));
        write_reg(REG_ROW_STEP, small_vec(100)); write_reg(REG_CENTER, '0);
        write_reg(REG_RADIUS, {20'd0, 40'hFF_FFFF_FFFF}); write_reg(REG_INV_DEG, 60'd0);
        write_reg(REG_COLS, 60'd4096); write_reg(REG_ROWS, 60'd2048);
      end
      default: begin
        write_reg(REG_CORNER, $urandom_range(0, 3) == 0 ? rand_vec() : small_vec(300000));
        write_reg(REG_COL_STEP, $urandom_range(0, 3) == 0 ? rand_vec() : small_vec(128));
        write_reg(REG_ROW_STEP, $urandom_range(0, 3) == 0 ? rand_vec() : small_vec(128));
        write_reg(REG_CENTER, $urandom_range(0, 3) == 0 ? rand_vec() : small_vec(300000));
        write_reg(REG_RADIUS, $urandom_range(0, 2) == 0 ? {20'd0, 8'($urandom), $urandom}
                                                       : {20'd0, 40'hFF_FFFF_FFFF});
        write_reg(REG_INV_DEG, $urandom_range(0, 1) ? 60'($urandom_range(1, 40000))
                                                    : 60'($urandom & 32'hFFFFF));
        write_reg(REG_COLS, $urandom_range(0, 1) ? 60'($urandom_range(1, 4096))
                                                 : 60'($urandom & 32'h1FFF));
        write_reg(REG_ROWS, $urandom_range(0, 1) ? 60'($urandom_range(1, 2048))
                                                 : 60'($urandom & 32'hFFF));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_req_t r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // defaults: zero radius drops every pixel
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
    drain();
    for (int ph = 0; ph < 10; ph++) begin
      set_phase(ph);
      idle_on = (ph != 4);
      if (ph < 3) begin
        for (int i = 0; i < 7; i++) begin
          r.frustum_row = (i & 1) ? 12'hFFF : 12'h000;
          r.frustum_col = (i & 2) ? 12'hFFF : 12'h000;
          r.blue = (i & 1) ? 8'hFF : 8'h00;
          r.green = (i & 2) ? 8'hFF : 8'h00;
          r.red = (i & 4) ? 8'hFF : 8'h00;
          send_pixel(i == 6 ? rand_pixel() : r);
        end
      end else begin
        for (int i = 0; i < 57; i++) send_pixel(rand_pixel());
      end
      drain();
    end
    if (sb.fails == 0 && sb.expected_px.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
